[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion helpers for the RTL folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, with reset masking the check.
`define ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/amcp_pkg.sv]
// ----------------------------------------------------------------------------
// amcp_pkg
// Types, character codes and helpers for the ASCII motor command parser.
// ----------------------------------------------------------------------------
package amcp_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_STEPS = 2'd0,
    KIND_CONT  = 2'd1,
    KIND_ACK   = 2'd2
  } kind_t;

  // Character codes
  localparam logic [7:0] CHR_0     = 8'h30;
  localparam logic [7:0] CHR_1     = 8'h31;
  localparam logic [7:0] CHR_2     = 8'h32;
  localparam logic [7:0] CHR_9     = 8'h39;
  localparam logic [7:0] CHR_LO_A  = 8'h61;
  localparam logic [7:0] CHR_LO_F  = 8'h66;
  localparam logic [7:0] CHR_UP_A  = 8'h41;
  localparam logic [7:0] CHR_UP_F  = 8'h46;

  // Characters per step record
  localparam logic [7:0] REC_LEN   = 8'd6;

  // Widths of the output payload
  localparam int ENGINE_W = 8;
  localparam int VALUE_W  = 16;

  // Hex character to nibble; anything that is not a hex digit maps to zero
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      if (c >= CHR_0 && c <= CHR_9) begin
        d = c - CHR_0;
      end else if (c >= CHR_LO_A && c <= CHR_LO_F) begin
        d = c - CHR_LO_A + 8'd10;
      end else if (c >= CHR_UP_A && c <= CHR_UP_F) begin
        d = c - CHR_UP_A + 8'd10;
      end
      hex_nibble = d[3:0];
    end
  endfunction

endpackage

[rtl/ascii_motor_command_parser_unit.sv]
// ----------------------------------------------------------------------------
// ascii_motor_command_parser_unit
// Byte-wise parser for ASCII motor command frames.
// ----------------------------------------------------------------------------
// The block takes one received character per cycle while the output is not
// stalled: each byte is captured in an input register, the frame state
// is updated by one pass of logic, and any command lands in a result
// register that drives the output. A byte flagged with s_tuser starts a
// new frame (length char); function '1' frames give one step-count command
// per six-character record with ack set on the last (an empty one gives an
// ack alone), function '2' gives one continuous-mode command.
// Back-pressure on the output stalls the input register and then s_tready.
`include "assert_macros.svh"

module ascii_motor_command_parser_unit (
  input  logic        clk,
  input  logic        rst,
  // Received characters
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tuser,   // [0] frame_start
  // Motor commands
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] engine, [8] dir, [24:9] value, [25] ack
  output logic [1:0]  m_tuser    // [1:0] kind
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FUNC,
    PH_REC_ENG,
    PH_REC_DIR,
    PH_REC_HEX,
    PH_C_ENG,
    PH_C_DIR,
    PH_C_CONT
  } phase_t;

  // Input register
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        frame_start;

  // Parser state
  phase_t      phase, phase_next;
  logic [7:0]  remaining, remaining_next;
  logic [7:0]  engine_hold, engine_hold_next;
  logic        dir_hold, dir_hold_next;
  logic [15:0] steps_acc, steps_acc_next;
  logic [1:0]  digit_count, digit_count_next;

  // Result register
  logic                          out_valid;
  amcp_pkg::kind_t               out_kind;
  logic [amcp_pkg::ENGINE_W-1:0] out_engine;
  logic                          out_dir;
  logic [amcp_pkg::VALUE_W-1:0]  out_value;
  logic                          out_ack;

  // Combinational result of the current byte
  logic                          emit;
  amcp_pkg::kind_t               res_kind;
  logic [amcp_pkg::ENGINE_W-1:0] res_engine;
  logic                          res_dir;
  logic [amcp_pkg::VALUE_W-1:0]  res_value;
  logic                          res_ack;

  logic        advance;
  logic [7:0]  dig;
  logic        rem_pos;
  logic [15:0] acc_shift;

  // Handshake: the held byte moves on when the result register can take it
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  assign dig       = in_byte - amcp_pkg::CHR_0;
  assign rem_pos   = (remaining != 8'd0) && !remaining[7];
  assign acc_shift = {steps_acc[11:0], amcp_pkg::hex_nibble(in_byte)};

  // Frame state update for one byte
  always_comb begin
    phase_next       = phase;
    remaining_next   = remaining;
    engine_hold_next = engine_hold;
    dir_hold_next    = dir_hold;
    steps_acc_next   = steps_acc;
    digit_count_next = digit_count;
    emit             = 1'b0;
    res_kind         = amcp_pkg::KIND_STEPS;
    res_engine       = engine_hold;
    res_dir          = dir_hold;
    res_value        = steps_acc;
    res_ack          = 1'b0;

    if (frame_start) begin
      remaining_next = dig;
      phase_next     = PH_FUNC;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          phase_next = PH_IDLE;
        end
        PH_FUNC: begin
          if (in_byte == amcp_pkg::CHR_1) begin
            if (rem_pos) begin
              phase_next = PH_REC_ENG;
            end else begin
              // empty step frame: ack alone
              phase_next = PH_IDLE;
              emit       = 1'b1;
              res_kind   = amcp_pkg::KIND_ACK;
              res_engine = '0;
              res_dir    = 1'b0;
              res_value  = '0;
              res_ack    = 1'b1;
            end
          end else if (in_byte == amcp_pkg::CHR_2) begin
            phase_next = PH_C_ENG;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_REC_ENG: begin
          remaining_next   = remaining - amcp_pkg::REC_LEN;
          engine_hold_next = dig;
          phase_next       = PH_REC_DIR;
        end
        PH_REC_DIR: begin
          dir_hold_next    = (dig != 8'd0);
          steps_acc_next   = '0;
          digit_count_next = 2'd0;
          phase_next       = PH_REC_HEX;
        end
        PH_REC_HEX: begin
          steps_acc_next = acc_shift;
          if (digit_count != 2'd3) begin
            digit_count_next = digit_count + 2'd1;
          end else begin
            // fourth digit closes the record
            digit_count_next = 2'd0;
            emit             = 1'b1;
            res_value        = acc_shift;
            res_ack          = !rem_pos;
            phase_next       = rem_pos ? PH_REC_ENG : PH_IDLE;
          end
        end
        PH_C_ENG: begin
          engine_hold_next = dig;
          phase_next       = PH_C_DIR;
        end
        PH_C_DIR: begin
          dir_hold_next = (dig != 8'd0);
          phase_next    = PH_C_CONT;
        end
        PH_C_CONT: begin
          phase_next = PH_IDLE;
          emit       = 1'b1;
          res_kind   = amcp_pkg::KIND_CONT;
          res_value  = {8'd0, dig};
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte     <= s_tdata;
      frame_start <= s_tuser;
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      remaining   <= '0;
      engine_hold <= '0;
      dir_hold    <= 1'b0;
      steps_acc   <= '0;
      digit_count <= '0;
    end else if (advance) begin
      phase       <= phase_next;
      remaining   <= remaining_next;
      engine_hold <= engine_hold_next;
      dir_hold    <= dir_hold_next;
      steps_acc   <= steps_acc_next;
      digit_count <= digit_count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (advance && emit) begin
      out_kind   <= res_kind;
      out_engine <= res_engine;
      out_dir    <= res_dir;
      out_value  <= res_value;
      out_ack    <= res_ack;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = {6'd0, out_ack, out_value, out_dir, out_engine};

  // Checks
  `ASSERT_NEXT(a_in_hold, clk, rst, in_valid && !advance,
               in_valid && $stable(in_byte) && $stable(frame_start),
               "held input byte changed while stalled")
  `ASSERT_IMPL(a_ack_kind, clk, rst, out_valid && out_ack,
               out_kind == amcp_pkg::KIND_STEPS || out_kind == amcp_pkg::KIND_ACK,
               "ack set on a continuous-mode command")
  `ASSERT_IMPL(a_ack_only, clk, rst, out_valid && out_kind == amcp_pkg::KIND_ACK,
               out_ack && out_engine == '0 && out_value == '0 && !out_dir,
               "ack-only command carries payload")
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !m_tready,
               out_valid && $stable(m_tdata) && $stable(m_tuser),
               "waiting command changed while stalled")

endmodule
